/* sv/spsc_pkg.sv */
// ----------------------------------------------------------------------------
// spsc_pkg
// Shared types, request codes and lookup tables for the pulse sound channel.
// ----------------------------------------------------------------------------
`default_nettype none

package spsc_pkg;

  // Request codes carried in req_type.
  localparam logic [2:0] REQ_REG_WRITE = 3'd0;
  localparam logic [2:0] REQ_CTRL_WRITE = 3'd1;
  localparam logic [2:0] REQ_STATUS_READ = 3'd2;
  localparam logic [2:0] REQ_TICK = 3'd3;
  localparam logic [2:0] REQ_LENGTH_CLK = 3'd4;
  localparam logic [2:0] REQ_SWEEP_CLK = 3'd5;
  localparam logic [2:0] REQ_ENVELOPE_CLK = 3'd6;

  // Channel register indexes.
  localparam logic [1:0] ADDR_VOLUME = 2'd0;
  localparam logic [1:0] ADDR_SWEEP = 2'd1;
  localparam logic [1:0] ADDR_PERIOD_LO = 2'd2;
  localparam logic [1:0] ADDR_PERIOD_HI = 2'd3;

  typedef struct packed {
    logic [2:0] req_type;
    logic [1:0] reg_addr;
    logic [7:0] write_data;
  } spsc_in_t;

  typedef struct packed {
    logic [3:0] sample;
    logic       sample_valid;
    logic       status;
  } spsc_out_t;

  // Length counter load values, indexed by the top five bits of a high period write.
  function automatic logic [7:0] length_lookup(input logic [4:0] idx);
    logic [7:0] val;
    unique case (idx)
      5'd0:  val = 8'd10;
      5'd1:  val = 8'd254;
      5'd2:  val = 8'd20;
      5'd3:  val = 8'd2;
      5'd4:  val = 8'd40;
      5'd5:  val = 8'd4;
      5'd6:  val = 8'd80;
      5'd7:  val = 8'd6;
      5'd8:  val = 8'd160;
      5'd9:  val = 8'd8;
      5'd10: val = 8'd60;
      5'd11: val = 8'd10;
      5'd12: val = 8'd14;
      5'd13: val = 8'd12;
      5'd14: val = 8'd26;
      5'd15: val = 8'd14;
      5'd16: val = 8'd12;
      5'd17: val = 8'd16;
      5'd18: val = 8'd24;
      5'd19: val = 8'd18;
      5'd20: val = 8'd48;
      5'd21: val = 8'd20;
      5'd22: val = 8'd96;
      5'd23: val = 8'd22;
      5'd24: val = 8'd192;
      5'd25: val = 8'd24;
      5'd26: val = 8'd72;
      5'd27: val = 8'd26;
      5'd28: val = 8'd16;
      5'd29: val = 8'd28;
      5'd30: val = 8'd32;
      5'd31: val = 8'd30;
      default: val = 8'd0;
    endcase
    return val;
  endfunction

  // Duty waveform bit for a given duty setting and sequencer step.
  function automatic logic duty_bit(input logic [1:0] sel, input logic [3:0] step);
    logic [15:0] pattern;
    unique case (sel)
      2'd0: pattern = 16'h0006;
      2'd1: pattern = 16'h001E;
      2'd2: pattern = 16'h01FE;
      2'd3: pattern = 16'hFFE1;
      default: pattern = 16'h0000;
    endcase
    return pattern[step];
  endfunction

endpackage

`default_nettype wire

/* sv/spsc_core.sv */
// ----------------------------------------------------------------------------
// spsc_core
// Channel state and its combinational update for one request word.
// ----------------------------------------------------------------------------
`default_nettype none

module spsc_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step_en,
  input  wire spsc_pkg::spsc_in_t item,
  output spsc_pkg::spsc_out_t     result
);
  import spsc_pkg::*;

  logic [1:0]  duty_select_r, duty_select_nxt;
  logic [3:0]  fixed_volume_r, fixed_volume_nxt;
  logic        loop_flag_r, loop_flag_nxt;
  logic        const_vol_r, const_vol_nxt;
  logic [4:0]  env_reload_r, env_reload_nxt;
  logic        sweep_enable_r, sweep_enable_nxt;
  logic [3:0]  sweep_reload_r, sweep_reload_nxt;
  logic        sweep_negate_r, sweep_negate_nxt;
  logic [2:0]  sweep_amount_r, sweep_amount_nxt;
  logic        sweep_pending_r, sweep_pending_nxt;
  logic [10:0] period_r, period_nxt;
  logic [7:0]  length_r, length_nxt;
  logic [3:0]  duty_step_r, duty_step_nxt;
  logic [3:0]  env_level_r, env_level_nxt;
  logic        enable_latch_r, enable_latch_nxt;
  logic        control_bit_r, control_bit_nxt;
  logic [11:0] timer_r, timer_nxt;
  logic [4:0]  env_count_r, env_count_nxt;
  logic [3:0]  sweep_count_r, sweep_count_nxt;
  logic [11:0] sweep_target_r, sweep_target_nxt;

  logic [10:0] shifted;
  logic [10:0] neg_sum;
  logic [11:0] target;
  logic [3:0]  sweep_dec;
  logic [3:0]  volume;
  logic        chan_ok;
  logic [3:0]  sample;
  logic        mixed;
  logic [7:0]  d;

  always_comb begin
    d = item.write_data;
    shifted = period_r >> sweep_amount_r;
    neg_sum = period_r + (shifted ^ 11'h7FF) + 11'd1;
    target = sweep_negate_r ? {1'b0, neg_sum} : ({1'b0, period_r} + {1'b0, shifted});
    sweep_dec = sweep_count_r - 4'd1;
    volume = const_vol_r ? fixed_volume_r : env_level_r;
    // The sweep target used here is the one left by the last sweep clock.
    chan_ok = (period_r > 11'd7) && enable_latch_r && (length_r != 8'd0) &&
              !sweep_target_r[11];

    duty_select_nxt = duty_select_r;
    fixed_volume_nxt = fixed_volume_r;
    loop_flag_nxt = loop_flag_r;
    const_vol_nxt = const_vol_r;
    env_reload_nxt = env_reload_r;
    sweep_enable_nxt = sweep_enable_r;
    sweep_reload_nxt = sweep_reload_r;
    sweep_negate_nxt = sweep_negate_r;
    sweep_amount_nxt = sweep_amount_r;
    sweep_pending_nxt = sweep_pending_r;
    period_nxt = period_r;
    length_nxt = length_r;
    duty_step_nxt = duty_step_r;
    env_level_nxt = env_level_r;
    enable_latch_nxt = enable_latch_r;
    control_bit_nxt = control_bit_r;
    timer_nxt = timer_r;
    env_count_nxt = env_count_r;
    sweep_count_nxt = sweep_count_r;
    sweep_target_nxt = sweep_target_r;
    sample = 4'd0;
    mixed = 1'b0;

    case (item.req_type)
      REQ_REG_WRITE: begin
        unique case (item.reg_addr)
          ADDR_VOLUME: begin
            duty_select_nxt = d[7:6];
            loop_flag_nxt = d[5];
            const_vol_nxt = d[4];
            fixed_volume_nxt = d[3:0];
            env_reload_nxt = {1'b0, d[3:0]} + 5'd1;
          end
          ADDR_SWEEP: begin
            sweep_enable_nxt = d[7];
            sweep_reload_nxt = {1'b0, d[6:4]} + 4'd1;
            sweep_negate_nxt = d[3];
            sweep_amount_nxt = d[2:0];
            sweep_pending_nxt = 1'b1;
          end
          ADDR_PERIOD_LO: begin
            period_nxt = {period_r[10:8], d};
          end
          ADDR_PERIOD_HI: begin
            period_nxt = {d[2:0], period_r[7:0]};
            length_nxt = length_lookup(d[7:3]) + 8'd1;
            duty_step_nxt = 4'd0;
            env_level_nxt = 4'd15;
            if (control_bit_r) begin
              enable_latch_nxt = 1'b1;
            end
          end
          default: ;
        endcase
      end
      REQ_CTRL_WRITE: begin
        control_bit_nxt = d[0];
        if (!d[0]) begin
          enable_latch_nxt = 1'b0;
        end
      end
      REQ_TICK: begin
        if (period_r != 11'd0) begin
          if (timer_r <= 12'd1) begin
            // A timer that sat at zero reloads one count short.
            timer_nxt = (timer_r == 12'd0) ? {1'b0, period_r} : ({1'b0, period_r} + 12'd1);
            if (chan_ok && (volume != 4'd0)) begin
              sample = duty_bit(duty_select_r, duty_step_r) ? volume : 4'd0;
              mixed = 1'b1;
            end
            duty_step_nxt = duty_step_r + 4'd1;
          end else begin
            timer_nxt = timer_r - 12'd1;
          end
        end
      end
      REQ_LENGTH_CLK: begin
        if (!loop_flag_r && (length_r != 8'd0)) begin
          length_nxt = length_r - 8'd1;
        end
      end
      REQ_SWEEP_CLK: begin
        sweep_target_nxt = target;
        sweep_count_nxt = sweep_dec;
        if (sweep_dec == 4'd0) begin
          sweep_count_nxt = sweep_reload_r;
          if (sweep_enable_r && (period_r > 11'd7) && !target[11] &&
              (sweep_amount_r != 3'd0)) begin
            period_nxt = target[10:0];
          end
        end
        if (sweep_pending_r) begin
          sweep_pending_nxt = 1'b0;
          sweep_count_nxt = sweep_reload_r;
        end
      end
      REQ_ENVELOPE_CLK: begin
        if (env_count_r == 5'd0) begin
          env_count_nxt = env_reload_r;
          if (!const_vol_r) begin
            if (loop_flag_r) begin
              env_level_nxt = env_level_r - 4'd1;
            end else if (env_level_r != 4'd0) begin
              env_level_nxt = env_level_r - 4'd1;
            end
          end
        end else begin
          env_count_nxt = env_count_r - 5'd1;
        end
      end
      default: ;
    endcase

    result.sample = sample;
    result.sample_valid = mixed;
    result.status = (length_nxt != 8'd0) && enable_latch_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_select_r <= 2'd0;
      fixed_volume_r <= 4'd0;
      loop_flag_r <= 1'b0;
      const_vol_r <= 1'b0;
      env_reload_r <= 5'd1;
      sweep_enable_r <= 1'b0;
      sweep_reload_r <= 4'd1;
      sweep_negate_r <= 1'b0;
      sweep_amount_r <= 3'd0;
      sweep_pending_r <= 1'b0;
      period_r <= 11'd0;
      length_r <= length_lookup(5'd0) + 8'd1;
      duty_step_r <= 4'd0;
      env_level_r <= 4'd15;
      enable_latch_r <= 1'b0;
      control_bit_r <= 1'b0;
      timer_r <= 12'd0;
      env_count_r <= 5'd0;
      sweep_count_r <= 4'd1;
      sweep_target_r <= 12'd0;
    end else if (step_en) begin
      duty_select_r <= duty_select_nxt;
      fixed_volume_r <= fixed_volume_nxt;
      loop_flag_r <= loop_flag_nxt;
      const_vol_r <= const_vol_nxt;
      env_reload_r <= env_reload_nxt;
      sweep_enable_r <= sweep_enable_nxt;
      sweep_reload_r <= sweep_reload_nxt;
      sweep_negate_r <= sweep_negate_nxt;
      sweep_amount_r <= sweep_amount_nxt;
      sweep_pending_r <= sweep_pending_nxt;
      period_r <= period_nxt;
      length_r <= length_nxt;
      duty_step_r <= duty_step_nxt;
      env_level_r <= env_level_nxt;
      enable_latch_r <= enable_latch_nxt;
      control_bit_r <= control_bit_nxt;
      timer_r <= timer_nxt;
      env_count_r <= env_count_nxt;
      sweep_count_r <= sweep_count_nxt;
      sweep_target_r <= sweep_target_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/square_pulse_sound_channel.sv */
// ----------------------------------------------------------------------------
// square_pulse_sound_channel
// Pulse sound channel with duty, timer, envelope, sweep and length units.
// ----------------------------------------------------------------------------
// Every request word (register write, control write, status read, timer tick
// or unit clock) yields exactly one result word carrying sample, sample_valid
// and status. The channel takes one word per clock while the output is not
// stalled. An accepted request word sits in the input register while the
// channel state update runs, and its result is caught in the output register
// once the output can advance. The state update is combinational from the
// registered state, so every word sees the state left by the one before it.
// A stalled output holds its word while one more request waits in the input
// register.
`default_nettype none

module square_pulse_sound_channel (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire spsc_pkg::spsc_in_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output spsc_pkg::spsc_out_t     out_data
);
  import spsc_pkg::*;

  spsc_in_t  in_r;
  logic      in_valid_r;
  spsc_out_t out_r;
  logic      out_valid_r;
  spsc_out_t result;
  logic      out_adv;
  logic      step_en;

  assign out_adv = !out_valid_r || !out_stall;
  assign step_en = in_valid_r && out_adv;
  assign in_stall = in_valid_r && !out_adv;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  spsc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_en(step_en),
    .item   (in_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (out_adv) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_r <= in_data;
    end
    if (step_en) begin
      out_r <= result;
    end
  end

  // A held request must still be held on the next cycle.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> in_valid_r)
    else $error("pending request word lost");

  // A stalled result word must not be dropped.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r)
    else $error("stalled result word lost");

  // Stall toward the source only when the input register is occupied and a valid output word is stalled.
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r && out_valid_r && out_stall)
    else $error("input stalled without cause");

  // An unmixed result carries a zero sample.
  a_no_sample: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.sample_valid |-> out_r.sample == 4'd0)
    else $error("sample set without sample_valid");

  // Nothing is presented right after reset.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !in_valid_r)
    else $error("valid set after reset");

endmodule

`default_nettype wire
